@@ sv/assert_macros.svh @@
// Assertion macros shared by the job table RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job table assertion failed");

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job table assertion failed");

`endif

@@ sv/jt_pkg.sv @@
// Shared types, widths and command codes of the job table.
// No dependencies; imported by the channel interfaces and the top level.
package jt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int CMD_W = 3;
  localparam int PID_W = 31;
  localparam int JOB_W = 5;
  localparam int ST_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_PID = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_JOB = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FG_PID   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ANY_OPEN = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

  // Run states
  localparam logic [ST_W-1:0] ST_UNDEFINED  = 2'd0;
  localparam logic [ST_W-1:0] ST_FOREGROUND = 2'd1;

  // Job id handed out first after reset
  localparam logic [JOB_W-1:0] JOB_FIRST = 5'd1;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [JOB_W-1:0] job;
    logic [ST_W-1:0]  state;
  } entry_t;

endpackage

@@ sv/jt_if.sv @@
// Valid/ready channel interfaces of the job table: command in, response out.
// Depends on jt_pkg for the field widths.
interface jt_cmd_if import jt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [PID_W-1:0] process_id;
  logic [JOB_W-1:0] job_number;
  logic [ST_W-1:0]  run_state;

  modport source(output valid, command, process_id, job_number, run_state, input ready);
  modport sink(input valid, command, process_id, job_number, run_state, output ready);
endinterface

interface jt_rsp_if import jt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             success;
  logic [PID_W-1:0] found_pid;
  logic [JOB_W-1:0] found_job;
  logic [ST_W-1:0]  found_state;
  logic             jobs_open;

  modport source(output valid, success, found_pid, found_job, found_state, jobs_open,
                 input ready);
  modport sink(input valid, success, found_pid, found_job, found_state, jobs_open,
               output ready);
endinterface

@@ sv/job_table_with_id_allocator.sv @@
// Job table with job id allocator: top level.
// Depends on jt_pkg, jt_if.sv and assert_macros.svh.
//
// Usage: one command word enters on cmd (valid/ready) and exactly one
// response word leaves on rsp (valid/ready). Commands: add, delete, find by
// process id, find by job id, first foreground process, any-open query and
// clear. The table lives in a single-port synchronous RAM of TABLE_ENTRIES
// words plus one valid flop per slot; a slot whose valid flop is low reads
// as empty.
// Sequencing: every command walks the whole RAM one slot a cycle, through
// the states SCAN, LAST and DONE, and the response is registered. A new
// command is taken only in IDLE, after the previous one has left DONE.
// Reset (synchronous, rst high) drops all valid flops, so the table is
// empty at once, and sets the next job id to 1.
// Stall: the response sits in an output register; cmd may take the next word
// while it waits. If the register is still full when the next command
// finishes its walk, that command holds its result until rsp is taken.
module job_table_with_id_allocator import jt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  jt_cmd_if.sink   cmd,
  jt_rsp_if.source rsp
);

`include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // Table storage
  entry_t mem [TABLE_ENTRIES];
  entry_t mem_q;

  logic [1:0]               state, state_next;
  logic [IDX_W-1:0]         cnt;
  logic                     rd_pending;
  logic [IDX_W-1:0]         rd_addr;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [JOB_W-1:0]         next_job;

  // Held command word
  logic [CMD_W-1:0] req_cmd;
  logic [PID_W-1:0] req_pid;
  logic [JOB_W-1:0] req_job;
  logic [ST_W-1:0]  req_st;

  // Walk results
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_data;
  logic [JOB_W-1:0] max_excl;
  logic             open_all;
  logic             open_excl;

  // Output register
  logic             out_valid;
  logic             out_success;
  logic [PID_W-1:0] out_pid;
  logic [JOB_W-1:0] out_job;
  logic [ST_W-1:0]  out_st;
  logic             out_open;

  entry_t           e;
  logic             cond;
  logic             take;
  logic             done_go;
  logic             add_ok;
  logic [JOB_W-1:0] job_inc;
  logic [JOB_W-1:0] add_next_job;

  // Handshakes
  assign cmd.ready = (state == S_IDLE);
  assign done_go   = (state == S_DONE) && (!out_valid || rsp.ready);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) state_next = S_SCAN;
      S_SCAN: if (cnt == IDX_LAST) state_next = S_LAST;
      S_LAST: state_next = S_DONE;
      S_DONE: if (done_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == S_SCAN);
      if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Read one slot a cycle; write back only at the end of a command
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      mem_q <= mem[cnt];
    end
    rd_addr <= cnt;
    if (done_go && add_ok) begin
      mem[hit_idx] <= '{pid: req_pid, job: next_job, state: req_st};
    end
  end

  // Match the slot that just came out of the RAM
  always_comb begin
    e = valid_bits[rd_addr] ? mem_q : '0;
    case (req_cmd)
      CMD_ADD:      cond = (e.pid == '0) && (req_pid != '0);
      CMD_DELETE,
      CMD_FIND_PID: cond = (e.pid == req_pid) && (req_pid != '0);
      CMD_FIND_JOB: cond = (e.job == req_job) && (req_job != '0);
      CMD_FG_PID:   cond = (e.state == ST_FOREGROUND);
      default:      cond = 1'b0;
    endcase
    take = rd_pending && cond && !hit_found;
  end

  // Capture the command and accumulate the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      hit_found <= 1'b0;
    end else if (take) begin
      hit_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      req_cmd   <= cmd.command;
      req_pid   <= cmd.process_id;
      req_job   <= cmd.job_number;
      req_st    <= cmd.run_state;
      max_excl  <= '0;
      open_all  <= 1'b0;
      open_excl <= 1'b0;
    end else if (rd_pending) begin
      if (e.state != ST_UNDEFINED) begin
        open_all <= 1'b1;
      end
      if (take) begin
        hit_idx  <= rd_addr;
        hit_data <= e;
      end else begin
        if (e.state != ST_UNDEFINED) open_excl <= 1'b1;
        if (e.job > max_excl) max_excl <= e.job;
      end
    end
  end

  // Job id allocation
  assign add_ok       = (req_cmd == CMD_ADD) && hit_found;
  assign job_inc      = next_job + 1'b1;
  assign add_next_job = (32'(job_inc) > TABLE_ENTRIES) ? JOB_FIRST : job_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_job   <= JOB_FIRST;
      valid_bits <= '0;
    end else if (done_go) begin
      if (add_ok) begin
        next_job            <= add_next_job;
        valid_bits[hit_idx] <= 1'b1;
      end else if (req_cmd == CMD_DELETE && hit_found) begin
        next_job            <= max_excl + 1'b1;
        valid_bits[hit_idx] <= 1'b0;
      end else if (req_cmd == CMD_CLEAR) begin
        valid_bits <= '0;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_success <= 1'b0;
      out_pid     <= '0;
      out_job     <= '0;
      out_st      <= '0;
      out_open    <= open_all;
      case (req_cmd)
        CMD_ADD: begin
          if (hit_found) begin
            out_success <= 1'b1;
            out_pid     <= req_pid;
            out_job     <= next_job;
            out_st      <= req_st;
            out_open    <= open_all || (req_st != ST_UNDEFINED);
          end
        end
        CMD_DELETE, CMD_FIND_PID, CMD_FIND_JOB, CMD_FG_PID: begin
          if (req_cmd == CMD_DELETE) out_open <= open_excl;
          if (hit_found) begin
            out_success <= 1'b1;
            out_pid     <= hit_data.pid;
            out_job     <= hit_data.job;
            out_st      <= hit_data.state;
          end
        end
        CMD_ANY_OPEN: out_success <= open_all;
        CMD_CLEAR: begin
          out_success <= 1'b1;
          out_open    <= 1'b0;
        end
        default: out_success <= 1'b0;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.success     = out_success;
  assign rsp.found_pid   = out_pid;
  assign rsp.found_job   = out_job;
  assign rsp.found_state = out_st;
  assign rsp.jobs_open   = out_open;

  // Checks
  `ASSERT_IMPL(a_rsp_from_done, $rose(rsp.valid), $past(state) == S_DONE)
  `ASSERT_NEXT(a_accept_walks, cmd.valid && cmd.ready, state == S_SCAN && cnt == '0)
  `ASSERT_NEXT(a_add_fills, done_go && add_ok, valid_bits[hit_idx])
  `ASSERT_NEXT(a_clear_empties, done_go && req_cmd == CMD_CLEAR, valid_bits == '0)

endmodule
